// ----- sv/mbe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int COORD_W    = 32;
  localparam int STEP_W     = 31;
  localparam int ITER_W     = 16;
  localparam int GREY_W     = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_RE = 4'd0,
    CFG_ORIGIN_IM = 4'd1,
    CFG_STEP      = 4'd2,
    CFG_MAX_ITER  = 4'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_re;
    logic signed [COORD_W-1:0] origin_im;
    logic [STEP_W-1:0]         step;
    logic [ITER_W-1:0]         max_iter;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic map_mul;
    logic map_add;
    logic iter_mul;
    logic iter_upd;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic limit_hit;
    logic escaped;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

// ----- sv/mbe_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mbe_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mbe_pkg::ITER_W-1:0] count,
  input  logic [mbe_pkg::ITER_W-1:0] divisor,
  output logic [mbe_pkg::GREY_W-1:0] grey,
  output logic                      done
);
  import mbe_pkg::*;

  localparam int DVD_W = ITER_W + GREY_W;
  localparam int CNT_W = $clog2(GREY_W);

  logic [DVD_W-1:0]  dvd_nxt;
  logic [ITER_W:0]   trial_nxt;
  logic              qbit_nxt;
  logic [ITER_W-1:0] rem_r;
  logic [ITER_W-1:0] dsr_r;
  logic [GREY_W-1:0] lo_r;
  logic              zero_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  // count * 255 as (count << 8) - count. Since count never exceeds the divisor,
  // the upper part of the dividend is already below it and only eight
  // quotient bits remain to be found.
  assign dvd_nxt   = {count, {GREY_W{1'b0}}} - DVD_W'(count);
  assign trial_nxt = {rem_r, lo_r[GREY_W-1]};
  assign qbit_nxt  = (trial_nxt >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(GREY_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(GREY_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dvd_nxt[DVD_W-1:GREY_W];
      lo_r   <= dvd_nxt[GREY_W-1:0];
      dsr_r  <= divisor;
      zero_r <= (divisor == '0);
    end else if (busy_r) begin
      if (qbit_nxt) begin
        rem_r <= ITER_W'(trial_nxt - {1'b0, dsr_r});
      end else begin
        rem_r <= trial_nxt[ITER_W-1:0];
      end
      lo_r <= {lo_r[GREY_W-2:0], qbit_nxt};
    end
  end

  assign grey = zero_r ? '0 : lo_r;
  assign done = done_r;

endmodule

`default_nettype wire

// ----- sv/mbe_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mbe_dp #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 26
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mbe_pkg::cfg_t               cfg,
  input  mbe_pkg::cmd_t               cmd,
  input  logic [COORD_BITS-1:0]       pixel_x,
  input  logic [COORD_BITS-1:0]       pixel_y,
  output mbe_pkg::status_t            status,
  output logic [mbe_pkg::ITER_W-1:0]  iter_count,
  output logic [mbe_pkg::GREY_W-1:0]  grey_level
);
  import mbe_pkg::*;

  localparam int PW        = COORD_BITS + STEP_W;
  localparam int SAT_W     = 66;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;
  localparam bit ESC_ON    = (ESC_SHIFT < PROD_W);
  localparam logic [PROD_W-1:0] ESC_THR =
    ESC_ON ? (PROD_W'(1) << (ESC_SHIFT % PROD_W)) : '0;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic fits;
    fits = (&v[SAT_W-1:COORD_W-1]) || !(|v[SAT_W-1:COORD_W-1]);
    if (fits) begin
      sat32 = v[COORD_W-1:0];
    end else if (v[SAT_W-1]) begin
      sat32 = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  logic [COORD_BITS-1:0]       px_r, py_r;
  logic [PW-1:0]               prodx_r, prody_r;
  logic signed [COORD_W-1:0]   c_re_r, c_im_r;
  logic signed [COORD_W-1:0]   za_r, zb_r;
  logic [ITER_W-1:0]           n_r;
  logic signed [PROD_W-1:0]    sa_r, sb_r, ab_r;
  logic [ITER_W-1:0]           iter_r;
  logic [GREY_W-1:0]           grey_r;

  logic [PW-1:0]               prodx_nxt, prody_nxt;
  logic signed [COORD_W-1:0]   c_re_nxt, c_im_nxt;
  logic signed [PROD_W-1:0]    sa_nxt, sb_nxt, ab_nxt;
  logic signed [PROD_W-1:0]    diff_nxt, re_sh_nxt, im_sh_nxt;
  logic signed [COORD_W-1:0]   za_nxt, zb_nxt;
  logic [PROD_W-1:0]           mag_nxt;
  logic [GREY_W-1:0]           div_grey;
  logic                        div_done;

  assign prodx_nxt = PW'(px_r) * PW'(cfg.step);
  assign prody_nxt = PW'(py_r) * PW'(cfg.step);
  assign c_re_nxt  = sat32(SAT_W'(cfg.origin_re) + SAT_W'($signed({1'b0, prodx_r})));
  assign c_im_nxt  = sat32(SAT_W'(cfg.origin_im) - SAT_W'($signed({1'b0, prody_r})));

  assign sa_nxt = PROD_W'(za_r) * PROD_W'(za_r);
  assign sb_nxt = PROD_W'(zb_r) * PROD_W'(zb_r);
  assign ab_nxt = PROD_W'(za_r) * PROD_W'(zb_r);

  // Arithmetic right shift floors, and the doubling of za*zb is folded into
  // the shift by one bit less.
  assign diff_nxt  = sa_r - sb_r;
  assign re_sh_nxt = diff_nxt >>> FRAC_BITS;
  assign im_sh_nxt = ab_r >>> (FRAC_BITS - 1);
  assign za_nxt    = sat32(SAT_W'(re_sh_nxt) + SAT_W'(c_re_r));
  assign zb_nxt    = sat32(SAT_W'(im_sh_nxt) + SAT_W'(c_im_r));
  assign mag_nxt   = $unsigned(sa_r) + $unsigned(sb_r);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      px_r <= pixel_x;
      py_r <= pixel_y;
    end
    if (cmd.map_mul) begin
      prodx_r <= prodx_nxt;
      prody_r <= prody_nxt;
    end
    if (cmd.map_add) begin
      c_re_r <= c_re_nxt;
      c_im_r <= c_im_nxt;
      za_r   <= '0;
      zb_r   <= '0;
      n_r    <= '0;
    end
    if (cmd.iter_mul) begin
      sa_r <= sa_nxt;
      sb_r <= sb_nxt;
      ab_r <= ab_nxt;
    end
    if (cmd.iter_upd) begin
      za_r <= za_nxt;
      zb_r <= zb_nxt;
      n_r  <= n_r + 1'b1;
    end
    if (cmd.out_load) begin
      iter_r <= n_r;
      grey_r <= div_grey;
    end
  end

  mbe_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .count   (n_r),
    .divisor (cfg.max_iter),
    .grey    (div_grey),
    .done    (div_done)
  );

  assign status.limit_hit = (n_r >= cfg.max_iter);
  assign status.escaped   = ESC_ON && (mag_nxt > ESC_THR);
  assign status.div_done  = div_done;

  assign iter_count = iter_r;
  assign grey_level = grey_r;

endmodule

`default_nettype wire

// ----- sv/mbe_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mbe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  mbe_pkg::status_t status,
  output mbe_pkg::cmd_t    cmd
);
  import mbe_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MAP  = 7'b0000010,
    S_CMAP = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_UPD  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MAP;
        end
      end
      S_MAP: begin
        cmd.map_mul = 1'b1;
        state_nxt   = S_CMAP;
      end
      S_CMAP: begin
        cmd.map_add = 1'b1;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        if (status.limit_hit) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.iter_mul = 1'b1;
          state_nxt    = S_UPD;
        end
      end
      S_UPD: begin
        if (status.escaped) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.iter_upd = 1'b1;
          state_nxt    = S_MUL;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // The result register may still hold the previous transaction.
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- sv/mandelbrot_escape_time.sv -----
// Mandelbrot escape-time evaluator. Each input transaction carries a pixel
// column and row; the block maps them to c = (origin_re + x*step,
// origin_im - y*step) in signed Q6.26, saturated, iterates z = z*z + c from
// zero until |z|^2 exceeds 4 or max_iter iterations are done, and returns the
// iteration count and the grey level floor(count*255/max_iter) (0 when
// max_iter is 0). One pixel is in flight at a time. Each iteration has a
// product step for the three 32x32 products and an update step for the
// escape test and the saturating update, and the grey level comes from an
// eight-bit restoring divider. A new pixel is accepted as soon as the
// previous result is in the output register, even if that result has not
// been taken yet. Configuration registers (origin_re, origin_im, step,
// max_iter at indexes 0 to 3) are written through the cfg port, which is
// always ready; writes to other indexes are ignored, and writes should only
// be made while no pixel is in flight.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 26
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [COORD_BITS-1:0]         in_pixel_x,
  input  logic [COORD_BITS-1:0]         in_pixel_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mbe_pkg::ITER_W-1:0]    out_iter_count,
  output logic [mbe_pkg::GREY_W-1:0]    out_grey_level
);
  import mbe_pkg::*;

  cfg_t    cfg_r;
  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_re <= -32'sd134217728;
      cfg_r.origin_im <= 32'sd134217728;
      cfg_r.step      <= 31'd268435;
      cfg_r.max_iter  <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ORIGIN_RE: cfg_r.origin_re <= $signed(cfg_data);
        CFG_ORIGIN_IM: cfg_r.origin_im <= $signed(cfg_data);
        CFG_STEP:      cfg_r.step      <= cfg_data[STEP_W-1:0];
        CFG_MAX_ITER:  cfg_r.max_iter  <= cfg_data[ITER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mbe_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .pixel_x    (in_pixel_x),
    .pixel_y    (in_pixel_y),
    .status     (status),
    .iter_count (out_iter_count),
    .grey_level (out_grey_level)
  );

  // Only one pixel is in flight, so acceptance must drop ready at once.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a pixel is in flight");

  // A result is loaded only from the final state, where no input is taken.
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a pixel being processed");

  // A zero count scales to a zero grey level, also when max_iter is zero.
  a_zero_count_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_iter_count == '0)) |-> (out_grey_level == '0))
    else $error("nonzero grey level for a zero iteration count");

endmodule

`default_nettype wire

// ----- verif/mandelbrot_escape_time_test.sv -----
`timescale 1ns / 1ps

module mandelbrot_escape_time_test;
  import mbe_pkg::*;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 26;
  localparam longint unsigned ESCAPE_LIMIT = 64'd4 << (2 * FRAC_BITS);

  // View that the block comes out of reset with: -2.0 + 2.0i, about 0.004 per pixel.
  localparam logic [31:0] DEFAULT_RE   = 32'hF800_0000;
  localparam logic [31:0] DEFAULT_IM   = 32'h0800_0000;
  localparam logic [31:0] DEFAULT_STEP = 32'd268435;
  localparam logic [31:0] DEFAULT_ITER = 32'd256;
  localparam logic [31:0] MINUS_HALF   = 32'hFE00_0000;

  typedef logic [COORD_BITS-1:0] pixel_t;

  typedef struct {
    logic [ITER_W-1:0] count;
    logic [GREY_W-1:0] grey;
  } escape_result_t;

  class escape_scoreboard;
    logic signed [COORD_W-1:0] origin_re;
    logic signed [COORD_W-1:0] origin_im;
    logic [STEP_W-1:0]         step_size;
    logic [ITER_W-1:0]         max_iter;
    escape_result_t            expected_q[$];
    int                        errors;

    function void reset_regs();
      origin_re = DEFAULT_RE;
      origin_im = DEFAULT_IM;
      step_size = DEFAULT_STEP[STEP_W-1:0];
      max_iter  = DEFAULT_ITER[ITER_W-1:0];
      errors    = 0;
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ORIGIN_RE: origin_re = data;
        CFG_ORIGIN_IM: origin_im = data;
        CFG_STEP:      step_size = data[STEP_W-1:0];
        CFG_MAX_ITER:  max_iter  = data[ITER_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function escape_result_t escape_time(pixel_t x, pixel_t y);
      longint c_re, c_im, za, zb, sa, sb, nre, nim;
      longint unsigned mag;
      int n;
      escape_result_t r;
      c_re = clamp32(longint'(origin_re) + longint'(x) * longint'(step_size));
      c_im = clamp32(longint'(origin_im) - longint'(y) * longint'(step_size));
      za = 0;
      zb = 0;
      n = 0;
      while (n < int'(max_iter)) begin
        sa = za * za;
        sb = zb * zb;
        // Both squares are below 2^62 + 1, so the sum fits unsigned 64 bits.
        mag = sa + sb;
        if (mag > ESCAPE_LIMIT) break;
        nre = clamp32(((sa - sb) >>> FRAC_BITS) + c_re);
        nim = clamp32(((za * zb) >>> (FRAC_BITS - 1)) + c_im);
        za = nre;
        zb = nim;
        n++;
      end
      r.count = ITER_W'(n);
      r.grey = (max_iter == 0) ? '0 : GREY_W'((n * 255) / int'(max_iter));
      return r;
    endfunction

    function void note_pixel(pixel_t x, pixel_t y);
      expected_q.push_back(escape_time(x, y));
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%0t mismatch: %s", $time, msg);
    endfunction

    function void check_result(logic [ITER_W-1:0] count, logic [GREY_W-1:0] grey);
      escape_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result count %0d grey %0d", count, grey));
        return;
      end
      want = expected_q.pop_front();
      if (count !== want.count || grey !== want.grey)
        report($sformatf("count %0d grey %0d, expected count %0d grey %0d",
                         count, grey, want.count, want.grey));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  pixel_t                in_pixel_x;
  pixel_t                in_pixel_y;
  logic                  out_valid;
  logic                  out_ready;
  logic [ITER_W-1:0]     out_iter_count;
  logic [GREY_W-1:0]     out_grey_level;

  escape_scoreboard escape_sb;
  int tx_idle_rate   = 0;
  int rx_idle_rate   = 0;
  int rx_hold_cycles = 0;

  mandelbrot_escape_time #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_iter_count(out_iter_count),
    .out_grey_level(out_grey_level)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every task below is entered and left at a falling edge.
  task automatic send_pixel(pixel_t x, pixel_t y);
    int gap;
    gap = 0;
    if (tx_idle_rate > 0 && $urandom_range(0, tx_idle_rate) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_pixel_x = x;
    in_pixel_y = y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    escape_sb.note_pixel(x, y);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid = 1'b0;
    while (escape_sb.pending() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    escape_sb.load_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_view(logic [31:0] re, logic [31:0] im, logic [31:0] stp,
                          logic [31:0] iters);
    cfg_write(CFG_ORIGIN_RE, re);
    cfg_write(CFG_ORIGIN_IM, im);
    cfg_write(CFG_STEP, stp);
    cfg_write(CFG_MAX_ITER, iters);
  endtask

  function automatic logic [31:0] wild_word();
    case ($urandom_range(0, 3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int n_items, bit quiet);
    logic [31:0] re, im, stp, iters;
    int shape;
    wait_drain();
    case ($urandom_range(0, 9))
      0:       iters = 1;
      1, 2, 3, 4, 5, 6: iters = $urandom_range(2, 64);
      default: iters = $urandom_range(65, 300);
    endcase
    shape = $urandom_range(0, 9);
    if (shape < 4) begin
      // Whole set across the pixel range, or its upper-left part.
      re  = DEFAULT_RE;
      im  = DEFAULT_IM;
      stp = 32'd65536 >> $urandom_range(0, 3);
    end else if (shape < 8) begin
      // Small window somewhere near the boundary.
      re  = $urandom_range(0, 167772160) - 134217728;
      im  = $urandom_range(0, 201326592) - 100663296;
      stp = $urandom_range(1, 16384);
    end else begin
      // Anywhere in the plane; data bits beyond the step and limit registers are junk.
      re    = wild_word();
      im    = wild_word();
      stp   = wild_word();
      iters = iters | ($urandom & 32'hFFFF_0000);
    end
    set_view(re, im, stp, iters);
    if (quiet) begin
      tx_idle_rate = 0;
      rx_idle_rate = 0;
    end else begin
      tx_idle_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      rx_idle_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    repeat (n_items) send_pixel(pixel_t'($urandom), pixel_t'($urandom));
  endtask

  initial begin : result_sink
    int gap;
    gap = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) escape_sb.check_result(out_iter_count, out_grey_level);
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_ready = 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_ready = 1'b0;
      end else if (rx_idle_rate > 0 && $urandom_range(0, rx_idle_rate) == 0) begin
        gap = $urandom_range(0, 14);
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin : stimulus
    escape_sb = new();
    escape_sb.reset_regs();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_pixel_x = '0;
    in_pixel_y = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset view: corners, alternating bit patterns, and a point near the origin.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'd0, 12'hFFF);
    send_pixel(12'd500, 12'd500);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);

    // A zero iteration limit gives zero count and zero grey.
    wait_drain();
    cfg_write(CFG_MAX_ITER, 32'd0);
    send_pixel(12'd500, 12'd500);
    send_pixel(12'hFFF, 12'hFFF);

    wait_drain();
    cfg_write(CFG_MAX_ITER, 32'd1);
    send_pixel(12'd500, 12'd500);
    send_pixel(12'd0, 12'd0);

    // Mapping overflows in both directions and saturates c.
    wait_drain();
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd3);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);
    wait_drain();
    set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd3);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd0, 12'd0);

    // Zero step puts every pixel on -0.5, which never escapes; the unused
    // indexes are written with junk afterwards and must change nothing.
    wait_drain();
    set_view(MINUS_HALF, 32'd0, 32'd0, 32'hFFFF);
    for (int i = int'(CFG_MAX_ITER) + 1; i < 2 ** CFG_IDX_W; i++)
      cfg_write(CFG_IDX_W'(i), $urandom);
    send_pixel(12'hFFF, 12'hFFF);

    wait_drain();
    set_view(DEFAULT_RE, DEFAULT_IM, DEFAULT_STEP, 32'hFFFF);
    send_pixel(12'd0, 12'd0);

    for (int p = 0; p < 12; p++) begin
      random_phase(70, p >= 10);
      if (p == 4) begin
        // The sink stalls long enough for two full-length pixels, so the
        // result register fills and the input backs up; then the source
        // holds off until all results are back.
        wait_drain();
        tx_idle_rate   = 0;
        rx_hold_cycles = 2000;
        repeat (8) send_pixel(pixel_t'($urandom), pixel_t'($urandom));
        wait_drain();
      end
    end

    wait_drain();
    repeat (40) @(negedge clk);
    if (escape_sb.errors == 0 && escape_sb.pending() == 0) begin
      $display("[mandelbrot_escape_time] OK");
    end else begin
      $display("[mandelbrot_escape_time] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(64'd50_000_000);
    $display("[mandelbrot_escape_time] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/mbe_pkg.sv
sv/mbe_div.sv
sv/mbe_dp.sv
sv/mbe_ctrl.sv
sv/mandelbrot_escape_time.sv
verif/mandelbrot_escape_time_test.sv
